[hdl/assert_macros.svh]
// Assertion macros for the checker file vct_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define VCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define VCT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/vct_pkg.sv]
// Shared types and constants for the value change tracker.
// No dependencies.
package vct_pkg;

   localparam int ENTRIES    = 16;
   localparam int FRAME_BITS = 32;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [15:0] FULL_MASK = 16'hffff;

   localparam logic KIND_SETUP  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      MODE_CAPTURE      = 3'd0,
      MODE_PREVIOUS     = 3'd1,
      MODE_CHANGE_FRAME = 3'd2,
      MODE_CHANGE_COUNT = 3'd3,
      MODE_EARLIER      = 3'd4
   } mode_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  element;
      logic [15:0] raw_value;
      logic [31:0] frame_number;
      logic [2:0]  set_mode;
      logic [15:0] set_mask;
      logic [15:0] set_match;
   } req_type;

   typedef struct packed {
      logic [3:0]  entry_index;
      logic [31:0] report;
   } rsp_type;

endpackage

[hdl/value_change_tracker_unit.sv]
// Value change tracker: per-entry mode/mask/match settings and change tracking.
// Depends on vct_pkg.
//
//   channel | direction | payload            | handshake
//   req_    | in        | vct_pkg::req_type  | req_valid / req_ready
//   rsp_    | out       | vct_pkg::rsp_type  | rsp_valid / rsp_ready
//
// An item is registered on accept. The entry read-modify-write and the result
// register load happen when the input register advances, and the result is
// then held in the result register; one item per cycle is sustained while
// results are taken. A set-up item gives no result. A full result register
// that is not taken holds the item in the input register and drops req_ready.
// Reset clears all entry state to its defaults; req_ready is low.
module value_change_tracker_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vct_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vct_pkg::rsp_type rsp_payload
);

   localparam int EN = vct_pkg::ENTRIES;
   localparam int FB = vct_pkg::FRAME_BITS;
   localparam int IW = vct_pkg::IDX_W;

   logic             item_valid_ff;
   vct_pkg::req_type item_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   vct_pkg::rsp_type rsp_ff;

   logic [2:0]    mode_ff   [EN];
   logic [15:0]   mask_ff   [EN];
   logic [15:0]   match_ff  [EN];
   logic [15:0]   latest_ff [EN];
   logic [15:0]   older_ff  [EN];
   logic [15:0]   seen_ff   [EN];
   logic [FB-1:0] cf_ff     [EN];
   logic [FB-1:0] ecf_ff    [EN];
   logic [31:0]   cnt_ff    [EN];

   logic [IW-1:0] idx;
   logic          in_range;
   logic          emits;
   logic          advance;
   logic          tbl_we;
   logic [15:0]   masked;
   logic [15:0]   filt;
   logic [FB-1:0] frame;
   logic [15:0]   latest_in;
   logic [15:0]   older_in;
   logic [15:0]   seen_in;
   logic [FB-1:0] cf_in;
   logic [FB-1:0] ecf_in;
   logic [31:0]   cnt_in;
   logic [31:0]   report_in;

   assign idx      = IW'(item_ff.element);
   assign in_range = int'(item_ff.element) < EN;
   assign emits    = (item_ff.kind == vct_pkg::KIND_SAMPLE) && in_range;
   assign advance  = item_valid_ff && (!emits || !rsp_valid_ff || rsp_ready);
   assign tbl_we   = advance && in_range;

   assign req_ready   = !reset && (!item_valid_ff || advance);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign frame  = FB'(item_ff.frame_number);
   assign masked = item_ff.raw_value & mask_ff[idx];
   assign filt   = (match_ff[idx] != 16'd0 && masked != match_ff[idx]) ? 16'd0 : masked;

   always_comb begin
      latest_in = latest_ff[idx];
      older_in  = older_ff[idx];
      seen_in   = seen_ff[idx];
      cf_in     = cf_ff[idx];
      ecf_in    = ecf_ff[idx];
      cnt_in    = cnt_ff[idx];
      report_in = 32'd0;
      case (vct_pkg::mode_type'(mode_ff[idx]))
         vct_pkg::MODE_CAPTURE: begin
            report_in = 32'(filt);
         end
         vct_pkg::MODE_PREVIOUS: begin
            if (latest_ff[idx] != filt) begin
               older_in  = latest_ff[idx];
               latest_in = filt;
            end
            report_in = 32'(older_in);
         end
         vct_pkg::MODE_CHANGE_FRAME: begin
            if (seen_ff[idx] != filt) begin
               seen_in = filt;
               cf_in   = frame;
            end
            report_in = 32'(cf_in);
         end
         vct_pkg::MODE_CHANGE_COUNT: begin
            if (seen_ff[idx] != filt) begin
               seen_in = filt;
               cnt_in  = cnt_ff[idx] + 32'd1;
            end
            report_in = cnt_in;
         end
         vct_pkg::MODE_EARLIER: begin
            if (seen_ff[idx] != filt) begin
               seen_in = filt;
               ecf_in  = cf_ff[idx];
               cf_in   = frame;
            end
            report_in = 32'(ecf_in);
         end
         default: begin
            report_in = 32'd0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && emits) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Input register and handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
      if (advance && emits) begin
         rsp_ff.entry_index <= item_ff.element;
         rsp_ff.report      <= report_in;
      end
   end

   // Entry tables: reset restores defaults, set-up writes settings and clears tracking, samples update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EN; i++) begin
            mode_ff[i]   <= 3'd0;
            mask_ff[i]   <= vct_pkg::FULL_MASK;
            match_ff[i]  <= 16'd0;
            latest_ff[i] <= 16'd0;
            older_ff[i]  <= 16'd0;
            seen_ff[i]   <= 16'd0;
            cf_ff[i]     <= '0;
            ecf_ff[i]    <= '0;
            cnt_ff[i]    <= 32'd0;
         end
      end else if (tbl_we) begin
         if (item_ff.kind == vct_pkg::KIND_SETUP) begin
            mode_ff[idx]   <= item_ff.set_mode;
            mask_ff[idx]   <= (item_ff.set_mask == 16'd0) ? vct_pkg::FULL_MASK
                                                          : item_ff.set_mask;
            match_ff[idx]  <= item_ff.set_match;
            latest_ff[idx] <= 16'd0;
            older_ff[idx]  <= 16'd0;
            seen_ff[idx]   <= 16'd0;
            cf_ff[idx]     <= '0;
            ecf_ff[idx]    <= '0;
            cnt_ff[idx]    <= 32'd0;
         end else begin
            latest_ff[idx] <= latest_in;
            older_ff[idx]  <= older_in;
            seen_ff[idx]   <= seen_in;
            cf_ff[idx]     <= cf_in;
            ecf_ff[idx]    <= ecf_in;
            cnt_ff[idx]    <= cnt_in;
         end
      end
   end

endmodule

[hdl/vct_checker.sv]
// Port-level checks for value_change_tracker_unit, bound into that module.
// Depends on vct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vct_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input vct_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vct_pkg::rsp_type rsp_payload
);

   `VCT_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `VCT_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid,
               "rsp item dropped")

   // A fresh result comes from an accepted sample item.
   `VCT_ASSERT(a_rsp_origin, clock, reset,
               $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) &&
                  ($past(req_payload.kind, 2) == vct_pkg::KIND_SAMPLE),
               "rsp item without sample item")

   `VCT_ASSERT(a_rsp_entry, clock, reset,
               $rose(rsp_valid) |-> rsp_payload.entry_index == $past(req_payload.element, 2),
               "rsp entry mismatch")

endmodule

bind value_change_tracker_unit vct_checker u_vct_checker (.*);

[bench/tb.sv]
// Self-checking testbench for value_change_tracker_unit: set-up and sample items
// go in, and each sample result is checked against an in-bench tracker of the table.
// Depends on vct_pkg and the value_change_tracker_unit RTL.
module tb;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1826;
   localparam int IDLE_PCT     = 11;
   localparam int QUIET_FROM   = 1200;
   localparam int QUIET_TO     = 1700;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int PRINT_CAP    = 100;
   localparam int ENTRIES      = vct_pkg::ENTRIES;
   localparam int FRAME_BITS   = vct_pkg::FRAME_BITS;

   // modes outside the defined set; the block must report zero for them
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   vct_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   vct_pkg::rsp_type rsp_payload;

   value_change_tracker_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // tracker copy of the entry table
   logic [2:0]            mode_tab    [ENTRIES];
   logic [15:0]           mask_tab    [ENTRIES];
   logic [15:0]           match_tab   [ENTRIES];
   logic [15:0]           latest_val  [ENTRIES];
   logic [15:0]           older_val   [ENTRIES];
   logic [15:0]           seen_val    [ENTRIES];
   logic [FRAME_BITS-1:0] chg_frame   [ENTRIES];
   logic [FRAME_BITS-1:0] early_frame [ENTRIES];
   logic [31:0]           chg_count   [ENTRIES];

   vct_pkg::req_type pending_items [$];
   vct_pkg::rsp_type report_queue  [$];

   int cycle_count     = 0;
   int error_count     = 0;
   int setups_sent     = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int hold_left       = 0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic logic may_idle();
      return !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      // keep the log short if the block is badly off
      if (error_count <= PRINT_CAP)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic track_item(input vct_pkg::req_type it);
      int               e;
      logic [15:0]      v;
      logic [31:0]      rep;
      vct_pkg::rsp_type want;
      e = int'(it.element);
      if (e >= ENTRIES) return;
      if (it.kind == vct_pkg::KIND_SETUP) begin
         mode_tab[e]    = it.set_mode;
         mask_tab[e]    = (it.set_mask == '0) ? vct_pkg::FULL_MASK : it.set_mask;
         match_tab[e]   = it.set_match;
         latest_val[e]  = '0;
         older_val[e]   = '0;
         seen_val[e]    = '0;
         chg_frame[e]   = '0;
         early_frame[e] = '0;
         chg_count[e]   = '0;
         return;
      end
      v = it.raw_value & mask_tab[e];
      if (match_tab[e] != '0 && v != match_tab[e]) v = '0;
      rep = '0;
      case (mode_tab[e])
         vct_pkg::MODE_CAPTURE: rep = 32'(v);
         vct_pkg::MODE_PREVIOUS: begin
            if (latest_val[e] != v) begin
               older_val[e]  = latest_val[e];
               latest_val[e] = v;
            end
            rep = 32'(older_val[e]);
         end
         vct_pkg::MODE_CHANGE_FRAME: begin
            if (seen_val[e] != v) begin
               seen_val[e]  = v;
               chg_frame[e] = FRAME_BITS'(it.frame_number);
            end
            rep = 32'(chg_frame[e]);
         end
         vct_pkg::MODE_CHANGE_COUNT: begin
            if (seen_val[e] != v) begin
               seen_val[e]  = v;
               chg_count[e] = chg_count[e] + 32'd1;
            end
            rep = chg_count[e];
         end
         vct_pkg::MODE_EARLIER: begin
            if (seen_val[e] != v) begin
               seen_val[e]    = v;
               early_frame[e] = chg_frame[e];
               chg_frame[e]   = FRAME_BITS'(it.frame_number);
            end
            rep = 32'(early_frame[e]);
         end
         default: rep = '0;
      endcase
      want.entry_index = it.element;
      want.report      = rep;
      report_queue.push_back(want);
   endtask

   // driver: predict on accept, then offer the next item or idle
   always @(posedge clock) begin : drive_proc
      logic take;
      take = req_valid && req_ready;
      if (take) begin
         track_item(req_payload);
         if (req_payload.kind == vct_pkg::KIND_SETUP) setups_sent++;
         else samples_sent++;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || take) begin
         if (pending_items.size() > 0 && !(may_idle() && $urandom_range(99) < IDLE_PCT)) begin
            req_payload <= pending_items.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each result against the oldest expectation, pace rsp_ready
   always @(posedge clock) begin : monitor_proc
      vct_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_queue.size() == 0) begin
            report_error($sformatf("unexpected result entry %0d report %h",
                                   rsp_payload.entry_index, rsp_payload.report));
         end else begin
            want = report_queue.pop_front();
            if (rsp_payload.entry_index !== want.entry_index)
               report_error($sformatf("entry_index %0d, expected %0d",
                                      rsp_payload.entry_index, want.entry_index));
            if (rsp_payload.report !== want.report)
               report_error($sformatf("entry %0d report %h, expected %h",
                                      want.entry_index, rsp_payload.report, want.report));
         end
         results_checked++;
         // long hold-off so the block fills and stalls its input
         if (results_checked == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(may_idle() && $urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic vct_pkg::req_type setup_item(input int e, input logic [2:0] mode,
                                                   input logic [15:0] mask,
                                                   input logic [15:0] match);
      vct_pkg::req_type it;
      it.kind         = vct_pkg::KIND_SETUP;
      it.element      = 4'(e);
      it.raw_value    = 16'($urandom);
      it.frame_number = $urandom;
      it.set_mode     = mode;
      it.set_mask     = mask;
      it.set_match    = match;
      return it;
   endfunction

   function automatic vct_pkg::req_type sample_item(input int e, input logic [15:0] raw,
                                                    input logic [31:0] frame);
      vct_pkg::req_type it;
      it.kind         = vct_pkg::KIND_SAMPLE;
      it.element      = 4'(e);
      it.raw_value    = raw;
      it.frame_number = frame;
      it.set_mode     = 3'($urandom);
      it.set_mask     = 16'($urandom);
      it.set_match    = 16'($urandom);
      return it;
   endfunction

   initial begin : main_proc
      logic [31:0] frame_ctr;
      logic [15:0] mask;
      logic [15:0] match;
      logic [15:0] raw;
      logic [2:0]  mode;
      int          e;

      for (int i = 0; i < ENTRIES; i++) begin
         mode_tab[i]    = vct_pkg::MODE_CAPTURE;
         mask_tab[i]    = vct_pkg::FULL_MASK;
         match_tab[i]   = '0;
         latest_val[i]  = '0;
         older_val[i]   = '0;
         seen_val[i]    = '0;
         chg_frame[i]   = '0;
         early_frame[i] = '0;
         chg_count[i]   = '0;
      end

      // directed: untouched entry, mask and match, each mode, unknown modes
      pending_items.push_back(sample_item(15, 16'hffff, 32'hffff_ffff));
      pending_items.push_back(setup_item(0, vct_pkg::MODE_CAPTURE, 16'h0000, 16'h0000));
      pending_items.push_back(sample_item(0, 16'hffff, 32'h0));
      pending_items.push_back(setup_item(1, vct_pkg::MODE_CAPTURE, 16'h00f0, 16'h0050));
      pending_items.push_back(sample_item(1, 16'h1257, 32'h1));
      pending_items.push_back(sample_item(1, 16'hff3f, 32'h2));
      pending_items.push_back(setup_item(2, vct_pkg::MODE_PREVIOUS, 16'hffff, 16'h0000));
      pending_items.push_back(sample_item(2, 16'h0005, 32'h3));
      pending_items.push_back(sample_item(2, 16'h0005, 32'h4));
      pending_items.push_back(sample_item(2, 16'h0009, 32'h5));
      pending_items.push_back(setup_item(3, vct_pkg::MODE_CHANGE_FRAME, 16'h0000, 16'h0000));
      pending_items.push_back(sample_item(3, 16'h0000, 32'd100));
      pending_items.push_back(sample_item(3, 16'h0007, 32'hffff_ffff));
      pending_items.push_back(sample_item(3, 16'h0007, 32'd3));
      pending_items.push_back(setup_item(4, vct_pkg::MODE_CHANGE_COUNT, 16'hffff, 16'hffff));
      pending_items.push_back(sample_item(4, 16'hffff, 32'd7));
      pending_items.push_back(sample_item(4, 16'hfffe, 32'd8));
      pending_items.push_back(setup_item(5, vct_pkg::MODE_EARLIER, 16'h0000, 16'h0000));
      pending_items.push_back(sample_item(5, 16'h0001, 32'd10));
      pending_items.push_back(sample_item(5, 16'h0002, 32'hffff_fff0));
      pending_items.push_back(setup_item(6, MODE_UNUSED_LO, 16'h0000, 16'h0000));
      pending_items.push_back(sample_item(6, 16'h1234, 32'd11));
      pending_items.push_back(setup_item(7, MODE_UNUSED_HI, 16'hffff, 16'h0000));
      pending_items.push_back(sample_item(7, 16'hffff, 32'd12));

      // random: mostly samples on a few busy entries with small values, so changes
      // and repeats both occur; now and then a fresh set-up
      frame_ctr = 32'd20;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         e = ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(ENTRIES - 1);
         if ($urandom_range(11) == 0) begin
            if ($urandom_range(9) == 0)
               mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else
               mode = 3'($urandom_range(vct_pkg::MODE_CAPTURE, vct_pkg::MODE_EARLIER));
            case ($urandom_range(3))
               0:       mask = 16'h0000;
               1:       mask = vct_pkg::FULL_MASK;
               2:       mask = 16'h000f;
               default: mask = 16'($urandom);
            endcase
            case ($urandom_range(5))
               0:       match = 16'($urandom_range(1, 3));
               1:       match = 16'($urandom);
               default: match = 16'h0000;
            endcase
            pending_items.push_back(setup_item(e, mode, mask, match));
         end else begin
            raw = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
            if ($urandom_range(15) == 0) frame_ctr = $urandom;
            else frame_ctr = frame_ctr + 32'($urandom_range(1, 3));
            pending_items.push_back(sample_item(e, raw, frame_ctr));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // drain: all items accepted, all results back, then a short settle
      @(negedge clock);
      while (pending_items.size() > 0 || req_valid) @(negedge clock);
      while (report_queue.size() > 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("Sent %0d set-up and %0d sample items over 16 entries, all modes incl. unknown.",
               setups_sent, samples_sent);
      $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
      if (error_count == 0 && report_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("Timed out after %0d cycles.", LIMIT_CYCLES);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
